// ----- rtl/core/des_ks_pkg.sv -----
// des_ks_pkg: constants, permutation tables and helper functions for the des key schedule
// used by des_ks_gen, des_ks_out and des_key_schedule; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package des_ks_pkg;

    localparam int KEY_BITS    = 64;
    localparam int ROUND_COUNT = 16;
    localparam int HALF_BITS   = 28;
    localparam int SUBKEY_BITS = 48;
    localparam int JOIN_BITS   = 2 * HALF_BITS;
    localparam int ROUND_BITS  = $clog2(ROUND_COUNT);
    localparam int POS_BITS    = 7;

    localparam logic [ROUND_BITS-1:0] LAST_ROUND = ROUND_BITS'(ROUND_COUNT - 1);

    // rounds that rotate both halves by two places; the others rotate by one
    localparam logic [ROUND_COUNT-1:0] ROT_DOUBLE = 16'h7EFC;

    // key bit selection into the c and d halves, positions 1-based from the key msb
    localparam logic [POS_BITS-1:0] PC1_C [HALF_BITS] = '{
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36
    };

    localparam logic [POS_BITS-1:0] PC1_D [HALF_BITS] = '{
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4
    };

    // compression selection from c:d to the subkey, positions 1-based from the msb of c:d
    localparam logic [POS_BITS-1:0] PC2 [SUBKEY_BITS] = '{
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    // one round's joined halves on their way to the compression selection
    typedef struct packed {
        logic [JOIN_BITS-1:0]  halves;
        logic [ROUND_BITS-1:0] round;
        logic                  last;
    } t_round_item;

    // c half selected from the key, parity bits dropped
    function automatic logic [HALF_BITS-1:0] pc1_c(input logic [KEY_BITS-1:0] key);
        logic [HALF_BITS-1:0] res;
        res = '0;
        for (int k = 0; k < HALF_BITS; k++) begin
            res[HALF_BITS-1-k] = key[KEY_BITS - int'(PC1_C[k])];
        end
        return res;
    endfunction

    // d half selected from the key, parity bits dropped
    function automatic logic [HALF_BITS-1:0] pc1_d(input logic [KEY_BITS-1:0] key);
        logic [HALF_BITS-1:0] res;
        res = '0;
        for (int k = 0; k < HALF_BITS; k++) begin
            res[HALF_BITS-1-k] = key[KEY_BITS - int'(PC1_D[k])];
        end
        return res;
    endfunction

    // compression selection over the joined halves
    function automatic logic [SUBKEY_BITS-1:0] pc2(input logic [JOIN_BITS-1:0] cd);
        logic [SUBKEY_BITS-1:0] res;
        res = '0;
        for (int k = 0; k < SUBKEY_BITS; k++) begin
            res[SUBKEY_BITS-1-k] = cd[JOIN_BITS - int'(PC2[k])];
        end
        return res;
    endfunction

    // left rotate of a half by one or two places
    function automatic logic [HALF_BITS-1:0] rot_half(input logic [HALF_BITS-1:0] h,
                                                      input logic dbl);
        logic [HALF_BITS-1:0] res;
        if (dbl) begin
            res = {h[HALF_BITS-3:0], h[HALF_BITS-1:HALF_BITS-2]};
        end else begin
            res = {h[HALF_BITS-2:0], h[HALF_BITS-1]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/des_ks_gen.sv -----
// des_ks_gen: c/d half registers and round counter of the key schedule
// depends on des_ks_pkg
`timescale 1ns / 1ps
`default_nettype none

module des_ks_gen
    import des_ks_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_key_valid,
    output logic                     o_key_ready,
    input  wire logic [KEY_BITS-1:0] i_key,
    output t_round_item              o_item,
    output logic                     o_item_valid,
    input  wire logic                i_item_ready
);

    logic                  r_busy;
    logic                  n_busy;
    logic [ROUND_BITS-1:0] r_round;
    logic [ROUND_BITS-1:0] n_round;
    logic [HALF_BITS-1:0]  r_c;
    logic [HALF_BITS-1:0]  n_c;
    logic [HALF_BITS-1:0]  r_d;
    logic [HALF_BITS-1:0]  n_d;
    logic [HALF_BITS-1:0]  w_c_rot;
    logic [HALF_BITS-1:0]  w_d_rot;
    logic                  w_last;
    logic                  w_fire;
    logic                  w_load;

    // rotate both halves for the current round
    always_comb begin
        w_c_rot = rot_half(r_c, ROT_DOUBLE[r_round]);
        w_d_rot = rot_half(r_d, ROT_DOUBLE[r_round]);
        w_last  = (r_round == LAST_ROUND);
    end

    // handshakes: a new key enters as the last round leaves
    always_comb begin
        o_item_valid  = r_busy;
        o_item.halves = {w_c_rot, w_d_rot};
        o_item.round  = r_round;
        o_item.last   = w_last;
        w_fire        = r_busy && i_item_ready;
        o_key_ready   = !r_busy || (w_fire && w_last);
        w_load        = i_key_valid && o_key_ready;
    end

    // next values of halves and round counter
    always_comb begin
        n_busy  = r_busy;
        n_round = r_round;
        n_c     = r_c;
        n_d     = r_d;
        if (w_load) begin
            n_busy  = 1'b1;
            n_round = '0;
            n_c     = pc1_c(i_key);
            n_d     = pc1_d(i_key);
        end else if (w_fire) begin
            n_busy  = !w_last;
            n_round = r_round + 1'b1;
            n_c     = w_c_rot;
            n_d     = w_d_rot;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else begin
            r_busy  <= n_busy;
            r_round <= n_round;
        end
    end

    // half registers
    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_d <= n_d;
    end

    // an accepted key starts at the first round
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_busy && r_round == '0))
        else $error("key load did not start at the first round");

    // after the last round leaves, either idle or a fresh key at round zero
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last) |=> (!r_busy || r_round == '0))
        else $error("run did not end after the last round");

    // a stalled round holds its counter and halves
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_item_ready) |=> ($stable(r_round) && $stable(r_c) && $stable(r_d)))
        else $error("round state moved while stalled");

    // idle means the counter sits at zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_round == '0))
        else $error("round counter nonzero while idle");

endmodule

`default_nettype wire

// ----- rtl/core/des_ks_out.sv -----
// des_ks_out: compression selection and the output register of the key schedule
// depends on des_ks_pkg
`timescale 1ns / 1ps
`default_nettype none

module des_ks_out
    import des_ks_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_round_item            i_item,
    input  wire logic                   i_item_valid,
    output logic                        o_item_ready,
    output logic [SUBKEY_BITS-1:0]      o_subkey,
    output logic [ROUND_BITS-1:0]       o_round,
    output logic                        o_last,
    output logic                        o_valid,
    input  wire logic                   i_ready
);

    logic                   r_valid;
    logic                   n_valid;
    logic [SUBKEY_BITS-1:0] r_subkey;
    logic [ROUND_BITS-1:0]  r_round;
    logic                   r_last;
    logic                   w_load;

    // register is free when empty or being drained
    always_comb begin
        o_item_ready = !r_valid || i_ready;
        w_load       = i_item_valid && o_item_ready;
        n_valid      = w_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // subkey and round registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_subkey <= pc2(i_item.halves);
            r_round  <= i_item.round;
            r_last   <= i_item.last;
        end
    end

    assign o_subkey = r_subkey;
    assign o_round  = r_round;
    assign o_last   = r_last;
    assign o_valid  = r_valid;

    // the last flag only rides on the final round
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_round == LAST_ROUND))
        else $error("last flag on a round other than the final one");

    // rounds of a run leave in order
    a_round_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !r_last && i_item_valid) |=>
            (r_round == $past(r_round) + 1'b1))
        else $error("round number skipped or repeated");

endmodule

`default_nettype wire

// ----- rtl/core/des_key_schedule.sv -----
// des_key_schedule: top level of the des key schedule, stream in and stream out
// depends on des_ks_pkg, des_ks_gen and des_ks_out
`timescale 1ns / 1ps
`default_nettype none

// Takes one 64-bit DES key per item (key bit 1 is the msb, parity bits ignored) and
// returns its sixteen 48-bit round subkeys, round 0 first, one item per cycle while
// the output side is ready, with the round index on tuser and tlast on the final
// round. The next key is accepted in the same cycle as the last subkey of the
// previous one leaves the round stage, so with the output side always ready keys
// stream without gaps. From key accept, the first subkey passes the half registers,
// then the output register. The output register decouples the two sides, and a
// stall on the output holds the round in place.
module des_key_schedule
    import des_ks_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [KEY_BITS-1:0]    s_axis_tdata,   // [63:0] cipher_key
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [SUBKEY_BITS-1:0]      m_axis_tdata,   // [47:0] round_subkey
    output logic [ROUND_BITS-1:0]       m_axis_tuser,   // [3:0] round_number
    output logic                        m_axis_tlast    // last_subkey
);

    t_round_item w_item;
    logic        w_item_valid;
    logic        w_item_ready;

    // half registers and round generation
    des_ks_gen u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_valid  (s_axis_tvalid),
        .o_key_ready  (s_axis_tready),
        .i_key        (s_axis_tdata),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready)
    );

    // subkey selection and output register
    des_ks_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .o_subkey     (m_axis_tdata),
        .o_round      (m_axis_tuser),
        .o_last       (m_axis_tlast),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready)
    );

endmodule

`default_nettype wire

// ----- tb/des_ks_checker.sv -----
// des_ks_checker: watches the key and subkey streams of des_key_schedule, predicts
// the sixteen round subkeys of each accepted key and compares them in order
// depends on des_ks_pkg for widths and the round count only
`timescale 1ns / 1ps

module des_ks_checker
    import des_ks_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_key_valid,
    input  wire logic                   i_key_ready,
    input  wire logic [KEY_BITS-1:0]    i_key_data,    // [63:0] cipher_key
    input  wire logic                   i_sub_valid,
    input  wire logic                   i_sub_ready,
    input  wire logic [SUBKEY_BITS-1:0] i_sub_data,    // [47:0] round_subkey
    input  wire logic [ROUND_BITS-1:0]  i_sub_user,    // [3:0] round_number
    input  wire logic                   i_sub_last,    // last_subkey
    output int                          o_fail_count,
    output int                          o_pending
);

    // key bit selection into the c and d halves, positions counted from the key msb
    localparam int SEL_C [HALF_BITS] = '{
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36
    };
    localparam int SEL_D [HALF_BITS] = '{
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4
    };

    // compression from c:d to the 48-bit subkey, positions from the msb of c:d
    localparam int SEL_SUBKEY [SUBKEY_BITS] = '{
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    // left rotation of both halves before each round
    localparam int ROUND_SHIFT [ROUND_COUNT] = '{
        1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1
    };

    typedef struct packed {
        logic [SUBKEY_BITS-1:0] subkey;
        logic [ROUND_BITS-1:0]  round;
        logic                   last;
    } t_subkey_item;

    t_subkey_item expected_subkeys [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // expand one key into its sixteen round subkeys
    task automatic expand_key(input logic [KEY_BITS-1:0] key);
        logic [HALF_BITS-1:0]   c;
        logic [HALF_BITS-1:0]   d;
        logic [JOIN_BITS-1:0]   cd;
        logic [SUBKEY_BITS-1:0] sk;
        t_subkey_item           item;
        for (int k = 0; k < HALF_BITS; k++) begin
            c[HALF_BITS-1-k] = key[KEY_BITS - SEL_C[k]];
            d[HALF_BITS-1-k] = key[KEY_BITS - SEL_D[k]];
        end
        for (int r = 0; r < ROUND_COUNT; r++) begin
            for (int n = 0; n < ROUND_SHIFT[r]; n++) begin
                c = {c[HALF_BITS-2:0], c[HALF_BITS-1]};
                d = {d[HALF_BITS-2:0], d[HALF_BITS-1]};
            end
            cd = {c, d};
            for (int k = 0; k < SUBKEY_BITS; k++) begin
                sk[SUBKEY_BITS-1-k] = cd[JOIN_BITS - SEL_SUBKEY[k]];
            end
            item.subkey = sk;
            item.round  = ROUND_BITS'(r);
            item.last   = (r == ROUND_COUNT - 1);
            expected_subkeys.push_back(item);
        end
    endtask

    // compare each accepted subkey item first, then queue the predictions of a new key
    always @(posedge i_clk) begin
        t_subkey_item want;
        if (i_rst_n) begin
            if (i_sub_valid && i_sub_ready) begin
                if (expected_subkeys.size() == 0) begin
                    $display("%0t: subkey item with none expected: subkey %h round %0d last %0d",
                             $time, i_sub_data, i_sub_user, i_sub_last);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_subkeys.pop_front();
                    if (i_sub_data !== want.subkey) begin
                        $display("%0t: round_subkey mismatch: expected %h, actual %h",
                                 $time, want.subkey, i_sub_data);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_sub_user !== want.round) begin
                        $display("%0t: round_number mismatch: expected %0d, actual %0d",
                                 $time, want.round, i_sub_user);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_sub_last !== want.last) begin
                        $display("%0t: last_subkey mismatch: expected %0d, actual %0d",
                                 $time, want.last, i_sub_last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_key_valid && i_key_ready) begin
                expand_key(i_key_data);
            end
        end
        o_pending <= expected_subkeys.size();
    end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives keys into des_key_schedule and back-pressures its subkey stream
// depends on des_ks_pkg, des_key_schedule and des_ks_checker
`timescale 1ns / 1ps

module testbench;
    import des_ks_pkg::*;

    localparam int RANDOM_PHASE_ITEMS = 135;
    localparam int PRESSURE_ITEMS     = 12;
    localparam int HOLD_CYCLES        = 300;
    localparam int DRAIN_CYCLES       = 20;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [KEY_BITS-1:0]    s_axis_tdata = '0;     // [63:0] cipher_key
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [SUBKEY_BITS-1:0] m_axis_tdata;          // [47:0] round_subkey
    logic [ROUND_BITS-1:0]  m_axis_tuser;          // [3:0] round_number
    logic                   m_axis_tlast;          // last_subkey

    int fail_count;
    int pending_subkeys;

    // idling controls, changed only at clock edges
    logic tx_random = 1'b0;
    logic rx_random = 1'b0;
    int   hold_req_seq = 0;

    logic [KEY_BITS-1:0] prev_key = '0;

    des_key_schedule dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    des_ks_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_valid  (s_axis_tvalid),
        .i_key_ready  (s_axis_tready),
        .i_key_data   (s_axis_tdata),
        .i_sub_valid  (m_axis_tvalid),
        .i_sub_ready  (m_axis_tready),
        .i_sub_data   (m_axis_tdata),
        .i_sub_user   (m_axis_tuser),
        .i_sub_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_subkeys)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle length: mostly short, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // random key: mostly uniform, some single-bit keys, some parity-only
    // variants of the previous key
    function automatic logic [KEY_BITS-1:0] random_key(input logic [KEY_BITS-1:0] prev);
        logic [KEY_BITS-1:0] parity_flip;
        case ($urandom_range(0, 9))
            0: begin
                parity_flip = {$urandom, $urandom} & 64'h0101_0101_0101_0101;
                return prev ^ parity_flip;
            end
            1: return 64'd1 << $urandom_range(0, KEY_BITS - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // offer one key item and hold it until accepted, then maybe idle
    task automatic push_key(input logic [KEY_BITS-1:0] key);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        prev_key = key;
        gap = 0;
        if (tx_random && $urandom_range(0, 99) < 40) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until every predicted subkey item has been seen
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_subkeys != 0) @(posedge i_clk);
    endtask

    // subkey receiver: random stalls, plus long hold-offs on request
    initial begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req_seq != hold_seen) begin
                hold_seen  = hold_req_seq;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_random && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [KEY_BITS-1:0] directed_keys [$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, parity-only keys, weak and semi-weak keys, the textbook key
        directed_keys = '{
            64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE,
            64'hE0E0_E0E0_F1F1_F1F1, 64'h1F1F_1F1F_0E0E_0E0E,
            64'h01FE_01FE_01FE_01FE, 64'hFE01_FE01_FE01_FE01,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
            64'h0000_0000_0000_0002, 64'h1334_5779_9BBC_DFF1,
            64'h1235_5678_9ABC_DEF0, 64'h0F0F_0F0F_0F0F_0F0F
        };
        foreach (directed_keys[i]) begin
            push_key(directed_keys[i]);
        end

        // random keys with idling on both sides
        tx_random <= 1'b1;
        rx_random <= 1'b1;
        for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
            push_key(random_key(prev_key));
        end

        // long receiver hold-off while keys keep coming, then pause until drained
        tx_random <= 1'b0;
        rx_random <= 1'b0;
        hold_req_seq <= hold_req_seq + 1;
        for (int i = 0; i < PRESSURE_ITEMS; i++) begin
            push_key(random_key(prev_key));
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // back-to-back keys, receiver always ready
        for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
            push_key(random_key(prev_key));
        end

        // random idling again
        tx_random <= 1'b1;
        rx_random <= 1'b1;
        for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
            push_key(random_key(prev_key));
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("des_key_schedule verification clean");
        end else begin
            $display("des_key_schedule verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #10ms;
        $display("des_key_schedule verification failed");
        $finish;
    end

endmodule
